// File: hdl/srr_pkg.sv
`default_nettype none
package srr_pkg;

   localparam int SEQ_W          = 8;
   localparam int LEN_W          = 10;
   localparam int HANDLE_W       = 8;
   localparam int FREE_W         = 5;
   localparam int REORDER_SLOTS_DEFAULT = 31;

   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   // one parked packet
   typedef struct packed {
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    length;
   } slot_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_INSERT = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_ACK    = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// File: hdl/srr_store.sv
`default_nettype none
module srr_store #(
   parameter int SLOTS = srr_pkg::REORDER_SLOTS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
   input  wire srr_pkg::slot_entry_type  wr_data,
   input  wire [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   output srr_pkg::slot_entry_type       rd_data
);
   import srr_pkg::*;

   // reorder store, one write and one registered read per cycle
   slot_entry_type mem [SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/selective_repeat_receiver.sv
`default_nettype none
// selective-repeat receiver
//
// input channel: a packet descriptor (sequence number, payload length, crc flag,
// buffer handle) is taken as a transaction on a clock edge with start high and
// busy low. bad-crc and old packets, and everything after the end of transfer,
// are dropped at once with no result and busy stays low.
// result channel: each result sits on the rsp_ ports for one cycle with
// rsp_strobe high; the receiver cannot stall, so the block never waits on it.
// an in-order packet gives its delivery in the cycle after acceptance, then the
// reorder store is scanned cyclically, one slot a cycle through the single
// store read port, delivering every buffered successor; the scan stops after
// REORDER_SLOTS slots in a row without a match, or on a zero-length delivery.
// the acknowledgement then follows with last_of_run set.
// a newer packet takes one pass over the store for the duplicate check and the
// lowest free slot; a duplicate, or a newer packet that finds the store full,
// is dropped at the end of that pass.
// reset clears the valid bits, the expected number, the fill count and the end
// flag; the store contents are only read behind a valid bit and need no clearing
module selective_repeat_receiver #(
   parameter int REORDER_SLOTS = srr_pkg::REORDER_SLOTS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire  [srr_pkg::SEQ_W-1:0]    req_seq_number,
   input  wire  [srr_pkg::LEN_W-1:0]    req_payload_length,
   input  wire                        req_crc_good,
   input  wire  [srr_pkg::HANDLE_W-1:0] req_buffer_handle,
   output logic                       rsp_strobe,
   output logic                       rsp_kind,
   output logic [srr_pkg::HANDLE_W-1:0] rsp_deliver_handle,
   output logic [srr_pkg::LEN_W-1:0]    rsp_deliver_length,
   output logic [srr_pkg::SEQ_W-1:0]    rsp_ack_seq,
   output logic [srr_pkg::FREE_W-1:0]   rsp_free_slots,
   output logic                       rsp_transfer_done,
   output logic                       rsp_last_of_run
);
   import srr_pkg::*;

   localparam int IDX_W  = (REORDER_SLOTS > 1) ? $clog2(REORDER_SLOTS) : 1;
   localparam int OCC_W  = $clog2(REORDER_SLOTS + 1);
   localparam int WIDE_W = (OCC_W > FREE_W) ? OCC_W : FREE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REORDER_SLOTS - 1);

   // sequencer and bookkeeping
   state_type            state_ff, state_in;
   logic [SEQ_W-1:0]     expected_ff, expected_in;
   logic [OCC_W-1:0]     occupied_ff, occupied_in;
   logic                 ended_ff, ended_in;
   logic [REORDER_SLOTS-1:0] valid_ff, valid_in;

   // scan pipeline: address issued, then slot checked in the cycle after
   logic [IDX_W-1:0]     addr_ff, addr_in, addr_next;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]     miss_ff, miss_in;

   // insertion scan results
   logic                 dup_ff, dup_in, dup_now;
   logic                 free_fnd_ff, free_fnd_in, free_fnd_now;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in, free_idx_now;

   // the held packet
   slot_entry_type       pkt_ff, pkt_in;

   // store port
   logic                 wr_en;
   slot_entry_type       rd_data;
   logic                 slot_live;
   logic                 drain_hit;

   // result register
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;
   logic [LEN_W-1:0]     rsp_length_ff, rsp_length_in;
   logic [SEQ_W-1:0]     rsp_ack_ff, rsp_ack_in;
   logic [FREE_W-1:0]    rsp_free_ff, rsp_free_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic [SEQ_W-1:0]     diff;
   logic [WIDE_W-1:0]    free_wide;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign diff      = req_seq_number - expected_ff;
   assign addr_next = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
   assign free_wide = WIDE_W'(REORDER_SLOTS) - WIDE_W'(occupied_ff);

   // slot under check, valid bit read live so a cleared slot never matches
   assign slot_live = chk_vld_ff && valid_ff[chk_idx_ff];
   assign drain_hit = slot_live && (rd_data.seq == expected_ff);

   // running duplicate and lowest-free-slot result including this check
   assign dup_now      = dup_ff || (slot_live && (rd_data.seq == pkt_ff.seq));
   assign free_fnd_now = free_fnd_ff || (chk_vld_ff && !valid_ff[chk_idx_ff]);
   assign free_idx_now = free_fnd_ff ? free_idx_ff : chk_idx_ff;

   srr_store #(
      .SLOTS (REORDER_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_now),
      .wr_data (pkt_ff),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      expected_in   = expected_ff;
      occupied_in   = occupied_ff;
      ended_in      = ended_ff;
      valid_in      = valid_ff;
      addr_in       = addr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = addr_ff;
      miss_in       = miss_ff;
      dup_in        = dup_ff;
      free_fnd_in   = free_fnd_ff;
      free_idx_in   = free_idx_ff;
      pkt_in        = pkt_ff;
      wr_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = KIND_DELIVER;
      rsp_handle_in = '0;
      rsp_length_in = '0;
      rsp_ack_in    = '0;
      rsp_free_in   = '0;
      rsp_done_in   = ended_ff;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !ended_ff && req_crc_good && !diff[SEQ_W-1]) begin
               pkt_in.seq    = req_seq_number;
               pkt_in.handle = req_buffer_handle;
               pkt_in.length = req_payload_length;
               addr_in       = '0;
               miss_in       = '0;
               if (diff == '0) begin
                  // in-order packet: deliver straight from the transaction
                  rsp_strobe_in = 1'b1;
                  rsp_handle_in = req_buffer_handle;
                  rsp_length_in = req_payload_length;
                  rsp_done_in   = (req_payload_length == '0);
                  ended_in      = (req_payload_length == '0);
                  expected_in   = expected_ff + 1'b1;
                  state_in      = (req_payload_length == '0) ? ST_ACK : ST_DRAIN;
               end else begin
                  dup_in      = 1'b0;
                  free_fnd_in = 1'b0;
                  state_in    = ST_INSERT;
               end
            end
         end

         ST_INSERT: begin
            addr_in     = addr_next;
            chk_vld_in  = 1'b1;
            dup_in      = dup_now;
            free_fnd_in = free_fnd_now;
            free_idx_in = free_idx_now;
            if (chk_vld_ff && (chk_idx_ff == LAST_IDX)) begin
               chk_vld_in = 1'b0;
               state_in   = ST_IDLE;
               if (!dup_now && free_fnd_now) begin
                  // park in the lowest free slot
                  wr_en                  = 1'b1;
                  valid_in[free_idx_now] = 1'b1;
                  occupied_in            = occupied_ff + 1'b1;
               end
            end
         end

         ST_DRAIN: begin
            addr_in    = addr_next;
            chk_vld_in = 1'b1;
            if (drain_hit) begin
               valid_in[chk_idx_ff] = 1'b0;
               occupied_in          = occupied_ff - 1'b1;
               expected_in          = expected_ff + 1'b1;
               miss_in              = '0;
               rsp_strobe_in        = 1'b1;
               rsp_handle_in        = rd_data.handle;
               rsp_length_in        = rd_data.length;
               if (rd_data.length == '0) begin
                  // end of transfer stops the drain
                  ended_in    = 1'b1;
                  rsp_done_in = 1'b1;
                  chk_vld_in  = 1'b0;
                  state_in    = ST_ACK;
               end
            end else if (chk_vld_ff) begin
               if (miss_ff == LAST_IDX) begin
                  // a full lap without a match: run is over
                  chk_vld_in = 1'b0;
                  state_in   = ST_ACK;
               end else begin
                  miss_in = miss_ff + 1'b1;
               end
            end
         end

         ST_ACK: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_ACK;
            rsp_ack_in    = expected_ff;
            rsp_free_in   = free_wide[FREE_W-1:0];
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expected_ff   <= '0;
         occupied_ff   <= '0;
         ended_ff      <= 1'b0;
         valid_ff      <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         occupied_ff   <= occupied_in;
         ended_ff      <= ended_in;
         valid_ff      <= valid_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      chk_idx_ff    <= chk_idx_in;
      miss_ff       <= miss_in;
      dup_ff        <= dup_in;
      free_fnd_ff   <= free_fnd_in;
      free_idx_ff   <= free_idx_in;
      pkt_ff        <= pkt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_length_ff <= rsp_length_in;
      rsp_ack_ff    <= rsp_ack_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_deliver_handle = rsp_handle_ff;
   assign rsp_deliver_length = rsp_length_ff;
   assign rsp_ack_seq        = rsp_ack_ff;
   assign rsp_free_slots     = rsp_free_ff;
   assign rsp_transfer_done  = rsp_done_ff;
   assign rsp_last_of_run    = rsp_last_ff;

endmodule
`default_nettype wire
